/* rtl/base58_string_decoder_top_defines.svh */
// ----------------------------------------------------------------------------
// Base58 string decoder assertion macros
// Shared assertion helpers for the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef BASE58_STRING_DECODER_TOP_DEFINES_SVH
`define BASE58_STRING_DECODER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

/* rtl/b58d_pkg.sv */
// ----------------------------------------------------------------------------
// Base58 decoder package
// Status codes, alphabet constants and the symbol-to-digit lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b58d_pkg;

   localparam int unsigned BASE         = 58;
   localparam int unsigned RESULT_LIMIT = 32;
   localparam logic [7:0]  ONE_CHAR     = 8'h31;  // '1'
   localparam logic [5:0]  ONES_MAX     = 6'd63;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [5:0] value;
   } digit_type;

   // Alphabet: 1-9, A-H, J-N, P-Z, a-k, m-z
   function automatic digit_type digit_of(input logic [7:0] ch);
      digit_type  d;
      logic [7:0] t;
      d.valid = 1'b1;
      t       = 8'h00;
      case (ch) inside
         [8'h31:8'h39]: t = ch - 8'h31;            // '1'..'9'
         [8'h41:8'h48]: t = ch - 8'h41 + 8'd9;     // 'A'..'H'
         [8'h4A:8'h4E]: t = ch - 8'h4A + 8'd17;    // 'J'..'N'
         [8'h50:8'h5A]: t = ch - 8'h50 + 8'd22;    // 'P'..'Z'
         [8'h61:8'h6B]: t = ch - 8'h61 + 8'd33;    // 'a'..'k'
         [8'h6D:8'h7A]: t = ch - 8'h6D + 8'd44;    // 'm'..'z'
         default:       d.valid = 1'b0;
      endcase
      d.value = t[5:0];
      return d;
   endfunction

endpackage

/* rtl/base58_string_decoder_top.sv */
// ----------------------------------------------------------------------------
// Base58 string decoder
// Folds Base58 characters into a byte store held in a synchronous RAM and
// streams out the decoded bytes, most significant first.
// ----------------------------------------------------------------------------
// One character is taken per req item; req_final_symbol marks the end of the
// string. A '1' ahead of any other digit, a character outside the alphabet,
// and any character that follows an error are handled in S_IDLE alone.
// Every other character starts a multiply pass over the store: the store RAM is
// read, multiplied by 58 plus carry and written back one byte per cycle, least
// significant byte first, through its single read and single write port. After
// the final character a decode state follows, then one rsp item per output
// cycle while rsp_stall is low: leading zero bytes for the leading '1's, then,
// after a state that fetches the first significant byte, the significant store
// bytes, with rsp_last_byte on the final one. A bad string gives a single rsp
// item with byte value 0 and an error status. The store is zeroed as its bytes
// are sent; after an error, and after reset, a clearing pass over every store
// byte runs, during which req_stall stays high.
// csr_write_data sets the longest accepted result (values above 32 act as 32).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "base58_string_decoder_top_defines.svh"

module base58_string_decoder_top
   import b58d_pkg::*;
#(
   parameter int unsigned STORE_BYTES = 32
) (
   input  logic       clock,
   input  logic       reset,
   // configuration
   input  logic       csr_write_enable,
   input  logic [5:0] csr_write_data,
   // input items
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_symbol,
   input  logic       req_final_symbol,
   // result items
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_byte_value,
   output logic [1:0] rsp_status,
   output logic       rsp_last_byte
);

   localparam int unsigned IDX_W  = $clog2(STORE_BYTES);
   localparam int unsigned BODY_W = $clog2(STORE_BYTES + 1);
   localparam int unsigned TOT_W  = ((BODY_W > 6) ? BODY_W : 6) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_BYTES - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DECIDE,
      S_ZEROS,
      S_PREP,
      S_BODY,
      S_ERR,
      S_CLEAR
   } state_type;

   // store RAM
   logic [7:0]       store_mem [STORE_BYTES];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [7:0]       wr_data;

   // control and string state
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [5:0]        carry_ff, carry_in;
   logic              fin_ff, fin_in;
   logic [5:0]        ones_ff, ones_in;
   logic              digit_seen_ff, digit_seen_in;
   status_type        error_ff, error_in;
   logic [BODY_W-1:0] body_ff, body_in;     // significant bytes in the store
   logic [TOT_W-1:0]  remain_ff, remain_in; // result items still to send
   logic [5:0]        max_bytes_ff;

   // output register
   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   status_type rsp_status_ff;
   logic       rsp_last_ff;
   logic       out_free;
   logic       out_load;
   logic [7:0] out_byte;
   status_type out_status;
   logic       out_last;

   digit_type         dig;
   logic [13:0]       prod;
   logic [TOT_W-1:0]  total;
   logic [TOT_W-1:0]  limit;
   logic [BODY_W-1:0] start_wide;

   assign dig        = digit_of(req_symbol);
   assign prod       = 14'(rd_data_ff) * 14'(BASE) + 14'(carry_ff);
   assign total      = TOT_W'(body_ff) + TOT_W'(ones_ff);
   assign limit      = (max_bytes_ff > 6'(RESULT_LIMIT)) ? TOT_W'(RESULT_LIMIT)
                                                         : TOT_W'(max_bytes_ff);
   assign start_wide = BODY_W'(STORE_BYTES) - body_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_byte_value = rsp_byte_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_last_byte  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      carry_in      = carry_ff;
      fin_in        = fin_ff;
      ones_in       = ones_ff;
      digit_seen_in = digit_seen_ff;
      error_in      = error_ff;
      body_in       = body_ff;
      remain_in     = remain_ff;
      rd_addr       = idx_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = 8'h00;
      out_load      = 1'b0;
      out_byte      = 8'h00;
      out_status    = STATUS_OK;
      out_last      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               fin_in   = req_final_symbol;
               state_in = req_final_symbol ? S_DECIDE : S_IDLE;
               if (error_ff != STATUS_OK) begin
                  // rest of a bad string is dropped
               end else if (!digit_seen_ff && req_symbol == ONE_CHAR) begin
                  if (ones_ff == ONES_MAX) begin
                     error_in = STATUS_TOO_LONG;
                  end else begin
                     ones_in = ones_ff + 6'd1;
                  end
               end else if (!dig.valid) begin
                  error_in = STATUS_INVALID;
               end else begin
                  // start multiply pass at the least significant byte
                  digit_seen_in = 1'b1;
                  carry_in      = dig.value;
                  idx_in        = LAST_IDX;
                  rd_addr       = LAST_IDX;
                  state_in      = S_MUL;
               end
            end
         end

         S_MUL: begin
            wr_en    = 1'b1;
            wr_data  = prod[7:0];
            carry_in = prod[13:8];
            if (prod[7:0] != 8'h00) begin
               body_in = BODY_W'(STORE_BYTES) - BODY_W'(idx_ff);
            end
            if (idx_ff != '0) begin
               idx_in  = idx_ff - 1'b1;
               rd_addr = idx_ff - 1'b1;
            end else begin
               if (prod[13:8] != 6'd0) begin
                  error_in = STATUS_TOO_LONG;
               end
               state_in = fin_ff ? S_DECIDE : S_IDLE;
            end
         end

         S_DECIDE: begin
            if (error_ff != STATUS_OK) begin
               state_in = S_ERR;
            end else if (total > limit) begin
               error_in = STATUS_TOO_LONG;
               state_in = S_ERR;
            end else if (total == '0) begin
               state_in = S_IDLE;
            end else begin
               remain_in = total;
               state_in  = (ones_ff != 6'd0) ? S_ZEROS : S_PREP;
            end
         end

         S_ZEROS: begin
            if (out_free) begin
               out_load  = 1'b1;
               out_last  = (remain_ff == TOT_W'(1));
               remain_in = remain_ff - 1'b1;
               ones_in   = ones_ff - 6'd1;
               if (ones_ff == 6'd1) begin
                  if (body_ff == '0) begin
                     digit_seen_in = 1'b0;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_PREP;
                  end
               end
            end
         end

         S_PREP: begin
            rd_addr  = start_wide[IDX_W-1:0];
            idx_in   = start_wide[IDX_W-1:0];
            state_in = S_BODY;
         end

         S_BODY: begin
            if (out_free) begin
               // send and zero this byte, fetch the next one
               out_load  = 1'b1;
               out_byte  = rd_data_ff;
               out_last  = (remain_ff == TOT_W'(1));
               wr_en     = 1'b1;
               remain_in = remain_ff - 1'b1;
               if (remain_ff == TOT_W'(1)) begin
                  ones_in       = 6'd0;
                  digit_seen_in = 1'b0;
                  body_in       = '0;
                  state_in      = S_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end

         S_ERR: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_status = error_ff;
               out_last   = 1'b1;
               idx_in     = '0;
               state_in   = S_CLEAR;
            end
         end

         S_CLEAR: begin
            wr_en = 1'b1;
            if (idx_ff == LAST_IDX) begin
               ones_in       = 6'd0;
               digit_seen_in = 1'b0;
               error_in      = STATUS_OK;
               body_in       = '0;
               state_in      = S_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         idx_ff        <= '0;
         carry_ff      <= 6'd0;
         fin_ff        <= 1'b0;
         ones_ff       <= 6'd0;
         digit_seen_ff <= 1'b0;
         error_ff      <= STATUS_OK;
         body_ff       <= '0;
         remain_ff     <= '0;
         max_bytes_ff  <= 6'd25;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         carry_ff      <= carry_in;
         fin_ff        <= fin_in;
         ones_ff       <= ones_in;
         digit_seen_ff <= digit_seen_in;
         error_ff      <= error_in;
         body_ff       <= body_in;
         remain_ff     <= remain_in;
         if (csr_write_enable) begin
            max_bytes_ff <= csr_write_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (out_load) begin
         rsp_byte_ff   <= out_byte;
         rsp_status_ff <= out_status;
         rsp_last_ff   <= out_last;
      end
   end

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   `ASSERT_PROP(a_err_single, clock, reset, (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_last_byte && rsp_byte_value == 8'h00), "error item must be a lone zero byte")
   `ASSERT_NEVER(a_no_overwrite, clock, reset, out_load && !out_free, "result register overwritten while stalled")
   `ASSERT_PROP(a_carry_range, clock, reset, (state_ff == S_MUL) |-> (carry_ff < 6'(BASE)), "multiply carry out of range")
   `ASSERT_PROP(a_body_fits, clock, reset, (state_ff == S_BODY) |-> (remain_ff != '0 && remain_ff <= TOT_W'(body_ff)), "byte count out of step with store")

endmodule
